// File: rtl/vfp_pkg.sv
// Package for the video frame packetizer.
// Holds shared constants, register indexes, the header kind and the record type.
// Used by vfp_framer, vfp_serializer and the top level; depends on nothing.
package vfp_pkg;

  localparam int LEN_BITS_DEF     = 24;
  localparam int PAYLOAD_BITS_DEF = 16;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 17;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PAYLOAD   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENCODING_TYPE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TS_INCREMENT  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PAYLOAD_KIND  = 2'd3;

  localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd1400;
  localparam logic        ENCODING_TYPE_RST = 1'b0;
  localparam logic [16:0] TS_INCREMENT_RST  = 17'd3000;
  localparam logic [6:0]  PAYLOAD_KIND_RST  = 7'd96;

  localparam int          HDR_FIRST   = 9;
  localparam int          HDR_NEXT    = 1;
  localparam int          MIN_PAYLOAD = 128;
  localparam logic [7:0]  CONT_MARK   = 8'hff;

  localparam int IDX_BITS = 4;
  localparam logic [IDX_BITS-1:0] IDX_W_LO  = 4'd1;
  localparam logic [IDX_BITS-1:0] IDX_W_HI  = 4'd2;
  localparam logic [IDX_BITS-1:0] IDX_H_LO  = 4'd5;
  localparam logic [IDX_BITS-1:0] IDX_H_HI  = 4'd6;
  localparam logic [IDX_BITS-1:0] IDX_FIRST_DATA = 4'(HDR_FIRST);
  localparam logic [IDX_BITS-1:0] IDX_CONT_DATA  = 4'(HDR_NEXT);

  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_CONT,
    HDR_FULL
  } hdr_kind_t;

  typedef struct packed {
    hdr_kind_t   kind;
    logic        enc;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  data;
    logic        last;
    logic        marker;
  } rec_t;

endpackage

// File: rtl/vfp_in_if.sv
// Input channel of the video frame packetizer: one frame byte per item.
// Depends on nothing.
interface vfp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic [23:0] frame_length;
  logic [15:0] frame_width;
  logic [15:0] frame_height;

  modport source (output valid, data_byte, frame_start, frame_length, frame_width,
                  frame_height, input ready);
  modport sink (input valid, data_byte, frame_start, frame_length, frame_width,
                frame_height, output ready);
endinterface

// File: rtl/vfp_out_if.sv
// Output channel of the video frame packetizer: one payload byte per item.
// Depends on nothing.
interface vfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        packet_first;
  logic        packet_last;
  logic        marker_bit;
  logic [16:0] ts_step;
  logic [6:0]  payload_type_out;
  logic        run_last;

  modport source (output valid, out_byte, packet_first, packet_last, marker_bit, ts_step,
                  payload_type_out, run_last, input ready);
  modport sink (input valid, out_byte, packet_first, packet_last, marker_bit, ts_step,
                payload_type_out, run_last, output ready);
endinterface

// File: rtl/vfp_framer.sv
// Frame and payload bookkeeping: tracks bytes left and payload fill, decides
// payload boundaries and builds one record per accepted byte while frame bytes are left. Uses vfp_pkg.
module vfp_framer #(
  parameter int LEN_BITS     = vfp_pkg::LEN_BITS_DEF,
  parameter int PAYLOAD_BITS = vfp_pkg::PAYLOAD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          frame_start,
  input  logic [23:0]   frame_length,
  input  logic [15:0]   frame_width,
  input  logic [15:0]   frame_height,
  input  logic [15:0]   max_payload,
  input  logic          encoding_type,
  output logic          push,
  output vfp_pkg::rec_t rec
);

  localparam int LB = (LEN_BITS < 24) ? LEN_BITS : 24;
  localparam int PB = PAYLOAD_BITS;
  localparam int CW = ((LB > PB) ? LB : PB) + 1;

  logic [LB-1:0] bytes_left;
  logic [PB-1:0] packet_fill;
  logic          packet_open;
  logic          first_packet;
  logic          packet_marker;

  logic [LB-1:0] bl_eff;
  logic          first_eff;
  logic          open_eff;
  logic [PB-1:0] fill_eff;
  logic          marker_eff;
  logic [PB-1:0] maxp;
  logic [PB-1:0] extra;
  logic [CW-1:0] total;
  logic          overflow;
  logic [PB-1:0] fill_cur;
  logic          marker_cur;
  logic [PB-1:0] fill_dec;
  logic          last;
  logic          active;

  always_comb begin
    bl_eff     = frame_start ? frame_length[LB-1:0] : bytes_left;
    first_eff  = frame_start | first_packet;
    open_eff   = !frame_start & packet_open;
    fill_eff   = frame_start ? '0 : packet_fill;
    marker_eff = !frame_start & packet_marker;
    maxp       = (max_payload[PB-1:0] < PB'(vfp_pkg::MIN_PAYLOAD)) ?
                 PB'(vfp_pkg::MIN_PAYLOAD) : max_payload[PB-1:0];
    extra      = first_eff ? PB'(vfp_pkg::HDR_FIRST) : PB'(vfp_pkg::HDR_NEXT);
    total      = CW'(bl_eff) + CW'(extra);
    overflow   = total > CW'(maxp);
    fill_cur   = open_eff ? fill_eff : (overflow ? maxp - extra : PB'(bl_eff));
    marker_cur = open_eff ? marker_eff : !overflow;
    fill_dec   = (fill_cur != '0) ? fill_cur - 1'b1 : '0;
    last       = fill_dec == '0;
    active     = bl_eff != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= '0;
      packet_fill   <= '0;
      packet_open   <= 1'b0;
      first_packet  <= 1'b1;
      packet_marker <= 1'b0;
    end else if (accept) begin
      if (active) begin
        bytes_left    <= bl_eff - 1'b1;
        packet_fill   <= fill_dec;
        packet_open   <= !last;
        first_packet  <= first_eff & !last;
        packet_marker <= marker_cur;
      end else begin
        bytes_left    <= bl_eff;
        packet_fill   <= fill_eff;
        packet_open   <= open_eff;
        first_packet  <= first_eff;
        packet_marker <= marker_eff;
      end
    end
  end

  always_comb begin
    push       = accept & active;
    rec.kind   = open_eff ? vfp_pkg::HDR_NONE :
                 (first_eff ? vfp_pkg::HDR_FULL : vfp_pkg::HDR_CONT);
    rec.enc    = encoding_type;
    rec.width  = frame_width;
    rec.height = frame_height;
    rec.data   = data_byte;
    rec.last   = last;
    rec.marker = marker_cur;
  end

endmodule

// File: rtl/vfp_serializer.sv
// Output stage: holds one record and sends its header bytes and data byte,
// one per cycle while packets.ready is high. Uses vfp_pkg and vfp_out_if.
module vfp_serializer (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vfp_pkg::rec_t rec_in,
  output logic          rec_ready,
  input  logic [16:0]   ts_increment,
  input  logic [6:0]    payload_kind,
  vfp_out_if.source     packets
);

  vfp_pkg::rec_t                 rec;
  logic                          rec_valid;
  logic [vfp_pkg::IDX_BITS-1:0]  idx;
  logic [vfp_pkg::IDX_BITS-1:0]  last_idx;
  logic                          on_data;
  logic                          take;

  always_comb begin
    unique case (rec.kind)
      vfp_pkg::HDR_FULL: last_idx = vfp_pkg::IDX_FIRST_DATA;
      vfp_pkg::HDR_CONT: last_idx = vfp_pkg::IDX_CONT_DATA;
      default:           last_idx = '0;
    endcase
    on_data   = idx == last_idx;
    take      = packets.valid & packets.ready;
    rec_ready = !rec_valid | (take & on_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      idx       <= '0;
    end else if (push) begin
      rec_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (on_data) begin
        rec_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rec <= rec_in;
    end
  end

  always_comb begin
    packets.valid = rec_valid;
    if (on_data) begin
      packets.out_byte = rec.data;
    end else if (rec.kind == vfp_pkg::HDR_CONT) begin
      packets.out_byte = vfp_pkg::CONT_MARK;
    end else begin
      case (idx)
        '0:                packets.out_byte = {7'd0, rec.enc};
        vfp_pkg::IDX_W_LO: packets.out_byte = rec.width[7:0];
        vfp_pkg::IDX_W_HI: packets.out_byte = rec.width[15:8];
        vfp_pkg::IDX_H_LO: packets.out_byte = rec.height[7:0];
        vfp_pkg::IDX_H_HI: packets.out_byte = rec.height[15:8];
        default:           packets.out_byte = 8'd0;
      endcase
    end
    packets.packet_first     = (idx == '0) & (rec.kind != vfp_pkg::HDR_NONE);
    packets.packet_last      = on_data & rec.last;
    packets.marker_bit       = rec.marker;
    packets.ts_step          = rec.marker ? ts_increment : 17'd0;
    packets.payload_type_out = payload_kind;
    packets.run_last         = on_data;
  end

endmodule

// File: rtl/video_frame_packetizer_unit.sv
// Top level of the video frame packetizer: configuration registers, framer
// and output serializer. Uses vfp_pkg, vfp_in_if, vfp_out_if, vfp_framer
// and vfp_serializer.
//
//   channel       role    moves per item
//   frame_bytes   sink    one frame byte with frame start, length and size
//   packets       source  one payload byte with marks, marker and timestamp step
//   cfg_*         write   one register write, no handshake back
//
// A frame byte is accepted in the cycle its record can enter the output
// register: a byte that continues a payload sends only its data byte, one
// that opens a later payload a continuation mark first and one that opens
// a frame the full header first; the output sends one byte a cycle while
// packets.ready is high. Reset is synchronous. A stalled output holds its
// byte and stops input intake once the record is due.
module video_frame_packetizer_unit #(
  parameter int LEN_BITS     = vfp_pkg::LEN_BITS_DEF,
  parameter int PAYLOAD_BITS = vfp_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vfp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [vfp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  vfp_in_if.sink                              frame_bytes,
  vfp_out_if.source                           packets
);

  logic [15:0]   max_payload;
  logic          encoding_type;
  logic [16:0]   ts_increment;
  logic [6:0]    payload_kind;
  logic          push;
  logic          rec_ready;
  vfp_pkg::rec_t rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload   <= vfp_pkg::MAX_PAYLOAD_RST;
      encoding_type <= vfp_pkg::ENCODING_TYPE_RST;
      ts_increment  <= vfp_pkg::TS_INCREMENT_RST;
      payload_kind  <= vfp_pkg::PAYLOAD_KIND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vfp_pkg::CFG_MAX_PAYLOAD:   max_payload   <= cfg_data[15:0];
        vfp_pkg::CFG_ENCODING_TYPE: encoding_type <= cfg_data[0];
        vfp_pkg::CFG_TS_INCREMENT:  ts_increment  <= cfg_data[16:0];
        vfp_pkg::CFG_PAYLOAD_KIND:  payload_kind  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign frame_bytes.ready = rec_ready;

  vfp_framer #(
    .LEN_BITS     (LEN_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_framer (
    .clk           (clk),
    .rst           (rst),
    .accept        (frame_bytes.valid & rec_ready),
    .data_byte     (frame_bytes.data_byte),
    .frame_start   (frame_bytes.frame_start),
    .frame_length  (frame_bytes.frame_length),
    .frame_width   (frame_bytes.frame_width),
    .frame_height  (frame_bytes.frame_height),
    .max_payload   (max_payload),
    .encoding_type (encoding_type),
    .push          (push),
    .rec           (rec)
  );

  vfp_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .rec_in       (rec),
    .rec_ready    (rec_ready),
    .ts_increment (ts_increment),
    .payload_kind (payload_kind),
    .packets      (packets)
  );

  a_first_not_run_end: assert property (@(posedge clk) disable iff (rst)
    packets.valid && packets.packet_first |-> !packets.run_last)
    else $error("payload opens on the last byte of an item");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    packets.valid && packets.packet_last |-> packets.run_last)
    else $error("payload ends on a header byte");

  a_ts_needs_marker: assert property (@(posedge clk) disable iff (rst)
    packets.valid && !packets.marker_bit |-> packets.ts_step == 17'd0)
    else $error("timestamp step without marker");

  a_push_only_when_free: assert property (@(posedge clk) disable iff (rst)
    push |-> rec_ready)
    else $error("record written over a pending record");

endmodule
